[hw/rtl/rk4_pkg.sv]
// Package for the RK4 three-equation integrator.
// Holds fixed-point constants, command and status types shared by the modules that import it.
package rk4_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_START_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL     = 3'd4;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned STEP_W     = 31;
  localparam int unsigned TOL_W      = 29;
  localparam int unsigned OUT_W      = 32;

  localparam logic [STEP_W-1:0] STEP_RESET = 31'd2684355;
  localparam logic [TOL_W-1:0]  TOL_RESET  = 29'd268;

  // datapath operation codes
  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,    // latch start of step (optionally restart), compute test
    OP_DERIV,   // evaluate one derivative for one coordinate at one stage
    OP_STAGE,   // form the next stage point
    OP_COMMIT   // combine and write back
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       restart;
    logic [1:0] coord;
    logic [1:0] stage;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic diverged;
  } dp_status_t;

endpackage

[hw/rtl/rk4_if.sv]
// Valid/ready channel interface for requests and results.
// Depends on nothing; payload width is a parameter.
interface rk4_if #(
  parameter int unsigned W = 1
) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/rk4_datapath.sv]
// Datapath: point registers, one shared derivative multiplier, a reciprocal
// multiply for the divide by six and saturating adders.
// Depends on rk4_pkg; sequenced by rk4_ctrl.
module rk4_datapath #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 28
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rk4_pkg::dp_cmd_t             cmd_i,
  output rk4_pkg::dp_status_t          status_o,
  input  logic signed [DATA_WIDTH-1:0] start_x_i,
  input  logic signed [DATA_WIDTH-1:0] start_y_i,
  input  logic signed [DATA_WIDTH-1:0] start_z_i,
  input  logic [rk4_pkg::STEP_W-1:0]   step_i,
  input  logic [rk4_pkg::TOL_W-1:0]    tol_i,
  output logic [rk4_pkg::OUT_W-1:0]    point_x_o,
  output logic [rk4_pkg::OUT_W-1:0]    point_y_o,
  output logic [rk4_pkg::OUT_W-1:0]    point_z_o
);
  import rk4_pkg::*;

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned PW = 2 * W;
  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
  // 1.0 and 2.0 saturated into the format
  localparam logic signed [W-1:0] ONE_FX =
      (FRAC_BITS >= W - 1) ? VMAX : W'(64'd1 << FRAC_BITS);
  localparam logic signed [W-1:0] TWO_FX =
      (FRAC_BITS + 1 >= W - 1) ? VMAX : W'(64'd2 << FRAC_BITS);
  // ceil(2^(W+2) / 6): exact quotient for magnitudes up to 2^(W-1)
  localparam logic [W-1:0] RECIP6 =
      W'(((PW+1)'(1) << (W + 2)) / (PW+1)'(6) + (PW+1)'(1));

  // saturating add
  function automatic logic signed [W-1:0] sadd(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) sadd = s[W] ? VMIN : VMAX;
    else sadd = s[W-1:0];
  endfunction

  // halve truncating toward zero
  function automatic logic signed [W-1:0] half(input logic signed [W-1:0] a);
    half = $signed(a + W'(a[W-1])) >>> 1;
  endfunction

  logic signed [W-1:0] cur_q [3], prev_q [3], base_q [3], pt_q [3];
  logic signed [W-1:0] k_q [4][3];
  logic signed [W-1:0] t_q, t_d;
  logic [1:0]          mphase_q, mphase_d;
  logic                diverged_q, diverged_d;

  // multiplier operands: magnitudes and sign
  logic signed [W-1:0] ma, mb;
  logic [W-1:0]        ua, ub;
  logic [PW-1:0]       prod;
  logic [PW-1:0]       shf;
  logic                neg;
  logic signed [W-1:0] mres;
  logic [1:0]          ci, c1, c2;

  // pick the derivative operands: a is the squared coordinate
  always_comb begin
    ci = cmd_i.coord;
    unique case (ci)
      2'd0: begin c1 = 2'd1; c2 = 2'd2; end
      2'd1: begin c1 = 2'd0; c2 = 2'd2; end
      default: begin c1 = 2'd1; c2 = 2'd0; end
    endcase
  end

  always_comb begin
    ma = t_q;
    mb = t_q;
    unique case (mphase_q)
      2'd0: begin ma = pt_q[ci]; mb = pt_q[ci]; end
      2'd1: begin ma = t_q; mb = pt_q[c1]; end
      2'd2: begin ma = t_q; mb = pt_q[c2]; end
      default: begin ma = W'($signed({1'b0, step_i})); mb = t_q; end
    endcase
  end

  always_comb begin
    ua   = ma[W-1] ? W'(-ma) : ma;
    ub   = mb[W-1] ? W'(-mb) : mb;
    neg  = ma[W-1] ^ mb[W-1];
    prod = {{W{1'b0}}, ua} * {{W{1'b0}}, ub};
    shf  = prod >> FRAC_BITS;
    if (neg) begin
      if (shf > PW'({1'b0, VMAX}) + PW'(1)) mres = VMIN;
      else mres = W'(-shf);
    end else begin
      if (shf > PW'({1'b0, VMAX})) mres = VMAX;
      else mres = shf[W-1:0];
    end
  end

  // derivative chain: square, 1-sq, times b, times c, times h
  always_comb begin
    t_d      = t_q;
    mphase_d = mphase_q;
    if (cmd_i.op == OP_DERIV) begin
      unique case (mphase_q)
        2'd0: t_d = sadd(ONE_FX, (mres == VMIN) ? VMAX : W'(-mres));
        default: t_d = mres;
      endcase
      mphase_d = mphase_q + 2'd1;
    end else begin
      mphase_d = 2'd0;
    end
  end

  // convergence test on the loaded point
  logic signed [W-1:0] lx [3], lp [3];
  logic [W:0]          ad [3];
  always_comb begin
    diverged_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      lx[i] = cur_q[i];
      lp[i] = prev_q[i];
      if (cmd_i.restart) begin
        lp[i] = TWO_FX;
      end
    end
    if (cmd_i.restart) begin
      lx[0] = start_x_i; lx[1] = start_y_i; lx[2] = start_z_i;
    end
    for (int i = 0; i < 3; i++) begin
      ad[i] = ($signed({lx[i][W-1], lx[i]}) >= $signed({lp[i][W-1], lp[i]})) ?
              {lx[i][W-1], lx[i]} - {lp[i][W-1], lp[i]} :
              {lp[i][W-1], lp[i]} - {lx[i][W-1], lx[i]};
      if (ad[i] > (W+1)'(tol_i)) diverged_d = 1'b1;
    end
  end

  // combine: (k1 + 2k2 + 2k3 + k4) / 6 for one coordinate
  logic signed [W-1:0] wsum;
  logic signed [W-1:0] q6;
  logic [W-1:0]        umag;
  logic [PW-1:0]       qprod;
  logic [W-1:0]        qtmp;
  always_comb begin
    wsum  = sadd(k_q[0][ci], sadd(k_q[1][ci], k_q[1][ci]));
    wsum  = sadd(wsum, sadd(k_q[2][ci], k_q[2][ci]));
    wsum  = sadd(wsum, k_q[3][ci]);
    umag  = wsum[W-1] ? W'(-wsum) : wsum;
    qprod = {{W{1'b0}}, umag} * {{W{1'b0}}, RECIP6};
    qtmp  = W'(qprod >> (W + 2));
    q6    = wsum[W-1] ? W'(-qtmp) : qtmp;
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        cur_q[i]  <= '0;
        prev_q[i] <= TWO_FX;
      end
      mphase_q   <= 2'd0;
      diverged_q <= 1'b0;
    end else begin
      mphase_q <= mphase_d;
      unique case (cmd_i.op)
        OP_LOAD: begin
          diverged_q <= diverged_d;
          for (int i = 0; i < 3; i++) begin
            cur_q[i]  <= lx[i];
            prev_q[i] <= lp[i];
          end
        end
        OP_COMMIT: begin
          prev_q[ci] <= base_q[ci];
          cur_q[ci]  <= sadd(base_q[ci], q6);
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    t_q <= t_d;
    unique case (cmd_i.op)
      OP_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          base_q[i] <= lx[i];
          pt_q[i]   <= lx[i];
        end
      end
      OP_DERIV: begin
        if (mphase_q == 2'd3) k_q[cmd_i.stage][ci] <= mres;
      end
      OP_STAGE: begin
        for (int i = 0; i < 3; i++) begin
          if (cmd_i.stage == 2'd2) pt_q[i] <= sadd(base_q[i], k_q[2][i]);
          else pt_q[i] <= sadd(base_q[i], half(k_q[cmd_i.stage][i]));
        end
      end
      default: ;
    endcase
  end

  assign status_o.busy     = (mphase_q != 2'd0);
  assign status_o.diverged = diverged_q;
  assign point_x_o = OUT_W'(base_q[0]);
  assign point_y_o = OUT_W'(base_q[1]);
  assign point_z_o = OUT_W'(base_q[2]);

endmodule

[hw/rtl/rk4_ctrl.sv]
// Controller: sequences load, derivative, stage and commit commands.
// Depends on rk4_pkg and drives rk4_datapath.
module rk4_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  logic                req_restart_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output logic                res_conv_o,
  output rk4_pkg::dp_cmd_t    cmd_o,
  input  rk4_pkg::dp_status_t status_i
);
  import rk4_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_TEST   = 3'd1;
  localparam logic [2:0] S_DERIV  = 3'd2;
  localparam logic [2:0] S_STAGE  = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0] state_q, state_d;
  logic [1:0] coord_q, coord_d, stage_q, stage_d;
  logic [1:0] dcnt_q, dcnt_d;
  logic       conv_q, conv_d;

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_OUT);
  assign res_conv_o  = conv_q;

  // next state and commands
  always_comb begin
    state_d     = state_q;
    coord_d     = coord_q;
    stage_d     = stage_q;
    dcnt_d      = dcnt_q;
    conv_d      = conv_q;
    cmd_o       = '0;
    cmd_o.op    = OP_NONE;
    cmd_o.coord = coord_q;
    cmd_o.stage = stage_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.op      = OP_LOAD;
          cmd_o.restart = req_restart_i;
          state_d       = S_TEST;
        end
      end
      S_TEST: begin
        coord_d = 2'd0;
        stage_d = 2'd0;
        dcnt_d  = 2'd0;
        conv_d  = !status_i.diverged;
        state_d = status_i.diverged ? S_DERIV : S_OUT;
      end
      S_DERIV: begin
        // four multiplier passes per coordinate
        cmd_o.op = OP_DERIV;
        dcnt_d   = dcnt_q + 2'd1;
        if (dcnt_q == 2'd3) begin
          if (coord_q == 2'd2) begin
            coord_d = 2'd0;
            state_d = (stage_q == 2'd3) ? S_COMMIT : S_STAGE;
          end else begin
            coord_d = coord_q + 2'd1;
          end
        end
      end
      S_STAGE: begin
        cmd_o.op = OP_STAGE;
        stage_d  = stage_q + 2'd1;
        state_d  = S_DERIV;
      end
      S_COMMIT: begin
        cmd_o.op = OP_COMMIT;
        if (coord_q == 2'd2) begin
          coord_d = 2'd0;
          state_d = S_OUT;
        end else begin
          coord_d = coord_q + 2'd1;
        end
      end
      S_OUT: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      coord_q <= 2'd0;
      stage_q <= 2'd0;
      dcnt_q  <= 2'd0;
      conv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      coord_q <= coord_d;
      stage_q <= stage_d;
      dcnt_q  <= dcnt_d;
      conv_q  <= conv_d;
    end
  end

  // multiplier phase must track the derivative pass counter
  a_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DERIV) |-> (status_i.busy == (dcnt_q != 2'd0)))
    else $error("multiplier phase out of step");
  // a result follows the test only when no step is needed
  a_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TEST && !status_i.diverged) |=> (state_q == S_OUT && conv_q))
    else $error("converged path skipped");
  // no request taken while a result waits
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_ready_o && res_valid_o))
    else $error("ready while result pending");

endmodule

[hw/rtl/rk4_triad_ode_step_unit.sv]
// Top level of the RK4 three-equation step unit.
// Depends on rk4_pkg, rk4_if, rk4_ctrl and rk4_datapath.
//
// Usage:
//   req channel carries one bit, restart. Each accepted request makes one
//   result on the res channel: {point_x, point_y, point_z, converged}.
//   A converged request goes from the test state straight to the result.
//   A step request runs the test, then 4 stages of 4 multiplier passes for
//   each of 3 coordinates on the shared derivative multiplier, 3 stage
//   updates between stages and one commit per coordinate. One request is
//   in work at a time; ready returns the cycle after the result is taken.
//   The user must make configuration writes (cfg_we_i, cfg_idx_i,
//   cfg_wdata_i) only while idle; the block does not enforce it. Index
//   0..2 start point, 3 step size, 4 tolerance. Reset puts the point at 0,
//   previous point at 2.0 and registers at their defaults. A stalled
//   receiver holds the result steady until taken.
module rk4_triad_ode_step_unit #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 28
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  rk4_if.sink                                 req,
  rk4_if.source                               res,
  input  logic                                cfg_we_i,
  input  logic [rk4_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [rk4_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);
  import rk4_pkg::*;

  logic signed [DATA_WIDTH-1:0] sx_q, sy_q, sz_q;
  logic [STEP_W-1:0]            step_q;
  logic [TOL_W-1:0]             tol_q;
  dp_cmd_t                      cmd;
  dp_status_t                   status;
  logic [OUT_W-1:0]             px, py, pz;
  logic                         conv;

  // widen or saturate a 32-bit start value into the datapath format
  function automatic logic signed [DATA_WIDTH-1:0] fit(input logic [CFG_DATA_W-1:0] v);
    logic signed [63:0] s;
    logic signed [63:0] hi, lo;
    s  = 64'($signed(v));
    hi = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (s > hi) fit = DATA_WIDTH'(hi);
    else if (s < lo) fit = DATA_WIDTH'(lo);
    else fit = DATA_WIDTH'(s);
  endfunction

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q   <= '0;
      sy_q   <= '0;
      sz_q   <= '0;
      step_q <= STEP_RESET;
      tol_q  <= TOL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START_X: sx_q <= fit(cfg_wdata_i);
        CFG_START_Y: sy_q <= fit(cfg_wdata_i);
        CFG_START_Z: sz_q <= fit(cfg_wdata_i);
        CFG_STEP:    step_q <= cfg_wdata_i[STEP_W-1:0];
        CFG_TOL:     tol_q <= cfg_wdata_i[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  rk4_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req.valid),
    .req_ready_o  (req.ready),
    .req_restart_i(req.data[0]),
    .res_valid_o  (res.valid),
    .res_ready_i  (res.ready),
    .res_conv_o   (conv),
    .cmd_o        (cmd),
    .status_i     (status)
  );

  rk4_datapath #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .status_o (status),
    .start_x_i(sx_q),
    .start_y_i(sy_q),
    .start_z_i(sz_q),
    .step_i   (step_q),
    .tol_i    (tol_q),
    .point_x_o(px),
    .point_y_o(py),
    .point_z_o(pz)
  );

  assign res.data = {px, py, pz, conv};

endmodule

[sim/rk4_step_checker.sv]
// Checker for the RK4 step unit: watches the request, result and config ports,
// predicts each result in Q4.28 fixed point and compares it field by field.
// Depends on rk4_pkg and rk4_if.
`timescale 1ns / 1ps

module rk4_step_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  rk4_if                                     req_mon,
  rk4_if                                     res_mon,
  input  logic                               cfg_we_i,
  input  logic [rk4_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rk4_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output int                                 errors_o,
  output int                                 pending_o
);
  import rk4_pkg::*;

  localparam int     FRAC = 28;
  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;
  localparam longint ONE_FX = 64'sd1 <<< FRAC;
  localparam longint TWO_FX = 64'sd2 <<< FRAC;

  typedef struct {
    logic [OUT_W-1:0] px;
    logic [OUT_W-1:0] py;
    logic [OUT_W-1:0] pz;
    logic             conv;
  } point_t;

  // register copies and integrator state
  longint start_x, start_y, start_z, cur_x, cur_y, cur_z, prev_x, prev_y, prev_z;
  longint step_h, tol;
  point_t expected_points[$];
  int     errors = 0;

  assign errors_o  = errors;
  assign pending_o = expected_points.size();

  function automatic longint clampw(longint v);
    if (v > VMAX) return VMAX;
    if (v < VMIN) return VMIN;
    return v;
  endfunction

  function automatic longint sat_add(longint a, longint b);
    return clampw(a + b);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    logic [63:0] ua, ub, p, lim;
    bit          neg;
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    neg = (a < 0) != (b < 0);
    p   = (ua * ub) >> FRAC;
    lim = VMAX + (neg ? 1 : 0);
    if (p > lim) p = lim;
    return neg ? -longint'(p) : longint'(p);
  endfunction

  // h * (1 - a^2) * b * c
  function automatic longint slope(longint a, longint b, longint c);
    longint t;
    t = sat_add(ONE_FX, -fx_mul(a, a));
    return fx_mul(step_h, fx_mul(fx_mul(t, b), c));
  endfunction

  function automatic longint blend(longint c, longint k1, longint k2, longint k3, longint k4);
    longint s;
    s = sat_add(k1, sat_add(k2, k2));
    s = sat_add(s, sat_add(k3, k3));
    s = sat_add(s, k4);
    return sat_add(c, s / 6);
  endfunction

  function automatic longint absdiff(longint a, longint b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // one request: reload on restart, test convergence, take an RK4 step when not converged
  function automatic point_t integrate(bit restart);
    point_t r;
    longint x, y, z, ax, ay, az;
    longint k[4], l[4], m[4];
    x = cur_x; y = cur_y; z = cur_z;
    if (restart) begin
      x = start_x; y = start_y; z = start_z;
      prev_x = TWO_FX; prev_y = TWO_FX; prev_z = TWO_FX;
    end
    r.px = x[31:0]; r.py = y[31:0]; r.pz = z[31:0];
    if (absdiff(x, prev_x) > tol || absdiff(y, prev_y) > tol || absdiff(z, prev_z) > tol) begin
      ax = x; ay = y; az = z;
      for (int s = 0; s < 4; s++) begin
        k[s] = slope(ax, ay, az);
        l[s] = slope(ay, ax, az);
        m[s] = slope(az, ay, ax);
        if (s < 2) begin
          ax = sat_add(x, k[s] / 2); ay = sat_add(y, l[s] / 2); az = sat_add(z, m[s] / 2);
        end else begin
          ax = sat_add(x, k[s]); ay = sat_add(y, l[s]); az = sat_add(z, m[s]);
        end
      end
      prev_x = x; prev_y = y; prev_z = z;
      cur_x = blend(x, k[0], k[1], k[2], k[3]);
      cur_y = blend(y, l[0], l[1], l[2], l[3]);
      cur_z = blend(z, m[0], m[1], m[2], m[3]);
      r.conv = 1'b0;
    end else begin
      cur_x = x; cur_y = y; cur_z = z;
      r.conv = 1'b1;
    end
    return r;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $realtime, field, got, want);
    errors++;
  endtask

  // track config, predict on request, compare on result
  always @(posedge clk_i or negedge rst_ni) begin
    point_t e;
    logic [96:0] d;
    if (!rst_ni) begin
      start_x = 0; start_y = 0; start_z = 0;
      step_h = STEP_RESET; tol = TOL_RESET;
      cur_x = 0; cur_y = 0; cur_z = 0;
      prev_x = TWO_FX; prev_y = TWO_FX; prev_z = TWO_FX;
      expected_points.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_START_X: start_x = longint'(signed'(cfg_wdata_i));
          CFG_START_Y: start_y = longint'(signed'(cfg_wdata_i));
          CFG_START_Z: start_z = longint'(signed'(cfg_wdata_i));
          CFG_STEP:    step_h  = cfg_wdata_i[STEP_W-1:0];
          CFG_TOL:     tol     = cfg_wdata_i[TOL_W-1:0];
          default: ;
        endcase
      end
      if (res_mon.valid && res_mon.ready) begin
        d = res_mon.data;
        if (expected_points.size() == 0) begin
          report("unexpected result", 32'(d[0]), 32'd0);
        end else begin
          e = expected_points.pop_front();
          if (d[96:65] !== e.px) report("point_x", d[96:65], e.px);
          if (d[64:33] !== e.py) report("point_y", d[64:33], e.py);
          if (d[32:1] !== e.pz)  report("point_z", d[32:1], e.pz);
          if (d[0] !== e.conv)   report("converged", 32'(d[0]), 32'(e.conv));
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        expected_points = {expected_points, integrate(req_mon.data[0])};
      end
    end
  end

endmodule

[sim/tb.sv]
// Top of the RK4 step unit testbench: clock, reset, request and config stimulus,
// result back-pressure and verdict. Depends on rk4_pkg, rk4_if, the unit, the checker.
`timescale 1ns / 1ps

module tb;
  import rk4_pkg::*;

  logic                  clk_i, rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  int                    errors, pending, sent;
  bit                    stim_done, calm;

  rk4_if #(.W(1))  req ();
  rk4_if #(.W(97)) res ();

  rk4_triad_ode_step_unit dut (
    .clk_i, .rst_ni, .req(req.sink), .res(res.source), .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  rk4_step_checker chk (
    .clk_i, .rst_ni, .req_mon(req), .res_mon(res), .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // offer one request and hold it until taken
  task automatic send_req(bit restart);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req.valid <= 1'b1;
    req.data  <= restart;
    do @(posedge clk_i); while (!(req.valid && req.ready));
    sent++;
  endtask

  // write one register while idle; the enable stays high for settle_and_config to drop
  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
  endtask

  task automatic settle_and_config(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                                   logic [31:0] h, logic [31:0] t);
    @(negedge clk_i);
    req.valid <= 1'b0;
    wait (pending == 0);
    repeat (60) @(posedge clk_i);
    write_cfg(CFG_START_X, sx);
    write_cfg(CFG_START_Y, sy);
    write_cfg(CFG_START_Z, sz);
    write_cfg(CFG_STEP, h);
    write_cfg(CFG_TOL, t);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
  endfunction

  // result side: random stalls, one long hold-off while requests keep coming
  initial begin
    int taken;
    taken = 0;
    res.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (taken == 120) begin
        res.ready <= 1'b0;
        repeat (400) @(negedge clk_i);
        taken++;
      end
      res.ready <= calm ? 1'b1 : (pick_gap() == 0);
      @(posedge clk_i);
      if (res.valid && res.ready) taken++;
    end
  end

  initial begin
    int n;
    req.valid = 1'b0; req.data = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = CFG_START_X; cfg_wdata_i = '0;
    rst_ni = 1'b0; sent = 0; stim_done = 0; calm = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // defaults: step away from reset state, then converge at the origin
    send_req(1'b0); send_req(1'b1); send_req(1'b0); send_req(1'b0);
    // start point at 2.0 with wide tolerance: restart is already converged
    settle_and_config(32'h2000_0000, 32'h2000_0000, 32'h2000_0000, 32'h7FFF_FFFF, 32'h1000_0000);
    send_req(1'b1); send_req(1'b0);
    // format extremes with largest step and zero tolerance: saturation
    settle_and_config(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
    repeat (5) send_req(1'b0);
    send_req(1'b1);
    settle_and_config(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0);
    send_req(1'b1); send_req(1'b0); send_req(1'b0);
    settle_and_config(32'hF000_0000, 32'h0800_0000, 32'hE000_0001, 32'h0400_0000, 32'h1);
    repeat (4) send_req(1'b0);
    send_req(1'b1);

    // random phases: fresh registers, restart first, then mostly plain steps
    while (sent < 1150) begin
      settle_and_config(rand_coord(), rand_coord(), rand_coord(),
                        ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0200_0000),
                        ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'h1000_0000)
                                                    : $urandom_range(0, 5000));
      calm = ($urandom_range(0, 5) == 0);
      send_req(1'b1);
      n = $urandom_range(30, 110);
      repeat (n) send_req($urandom_range(0, 9) == 0);
      calm = 0;
    end

    @(negedge clk_i);
    req.valid <= 1'b0;
    wait (pending == 0);
    repeat (80) @(posedge clk_i);
    if (errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

  initial begin
    #10ms;
    $display("tb failed");
    $finish;
  end
endmodule

[rk4_triad_ode_step_unit.f]
hw/rtl/rk4_pkg.sv
hw/rtl/rk4_if.sv
hw/rtl/rk4_datapath.sv
hw/rtl/rk4_ctrl.sv
hw/rtl/rk4_triad_ode_step_unit.sv
sim/rk4_step_checker.sv
sim/tb.sv
